// ----- hdl/vpdi_pkg.sv -----
// ----------------------------------------------------------------------------
// vpdi_pkg
// Shared types and constants of the vertex pair dedupe indexer.
// ----------------------------------------------------------------------------
package vpdi_pkg;
	localparam int TableDepth = 4096;
	localparam int AddrW  = $clog2(TableDepth);
	localparam int CountW = $clog2(TableDepth + 1);
	localparam int PosW   = 11;
	localparam int TexW   = 16;
	localparam int KeyW   = PosW + TexW;
	localparam int VertW  = 12;
	localparam int UcntW  = 13;

	typedef struct packed {
		logic [PosW-1:0] pos_index;
		logic [TexW-1:0] tex_index;
		logic            last_corner;
	} in_word_t;

	typedef struct packed {
		logic [VertW-1:0] vert_index;
		logic             was_new;
		logic             overflow;
		logic [UcntW-1:0] unique_count;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic append;
		logic emit_hit;
		logic emit_miss;
		logic clear;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic full;
	} ctl_sts_t;
endpackage

// ----- hdl/vpdi_if.sv -----
// ----------------------------------------------------------------------------
// vpdi_if
// Valid/ready channel carrying one word.
// ----------------------------------------------------------------------------
interface vpdi_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/vertex_pair_dedupe_indexer_core.sv -----
// ----------------------------------------------------------------------------
// vertex_pair_dedupe_indexer_core
// Each word is looked up by a scan of the stored pairs, one table read a cycle,
// that ends at the first hit or after the last stored pair.
// A new word is taken only after the last one's result is emitted; a held result stalls the scan
// end. Reset empties the table at once (count cleared); contents need no clear.
// ----------------------------------------------------------------------------
module vertex_pair_dedupe_indexer_core (
	input logic clk,
	input logic arst_n,
	vpdi_if.sink   in_ch,
	vpdi_if.source out_ch
);
	vpdi_pkg::ctl_cmd_t cmd;
	vpdi_pkg::ctl_sts_t sts;

	vpdi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vpdi_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_ch.data),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (out_ch.data)
	);
endmodule

// ----- hdl/vpdi_ram.sv -----
// ----------------------------------------------------------------------------
// vpdi_ram
// Simple dual port generic RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module vpdi_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- hdl/vpdi_datapath.sv -----
// ----------------------------------------------------------------------------
// vpdi_datapath
// Key register, scan counter, pair count, table RAM and result register.
// ----------------------------------------------------------------------------
module vpdi_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  vpdi_pkg::in_word_t  in_word,
	input  vpdi_pkg::ctl_cmd_t  cmd,
	output vpdi_pkg::ctl_sts_t  sts,
	output vpdi_pkg::out_word_t out_word
);
	logic [vpdi_pkg::KeyW-1:0]   key_q;
	logic                        last_q;
	logic [vpdi_pkg::CountW-1:0] count_q;
	logic [vpdi_pkg::CountW-1:0] scan_q;
	logic [vpdi_pkg::CountW-1:0] cmp_q;
	logic                        cmp_vld_q;
	logic                        hit_q;
	logic [vpdi_pkg::CountW-1:0] hit_idx_q;
	logic [vpdi_pkg::KeyW-1:0]   rdata;
	logic [vpdi_pkg::AddrW-1:0]  raddr;
	logic [vpdi_pkg::CountW-1:0] new_count;
	logic                        match;

	assign raddr = scan_q[vpdi_pkg::AddrW-1:0];
	assign match = cmp_vld_q && (rdata == key_q);
	assign new_count = count_q + vpdi_pkg::CountW'(1);

	vpdi_ram #(.Width(vpdi_pkg::KeyW), .Depth(vpdi_pkg::TableDepth)) u_table (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (count_q[vpdi_pkg::AddrW-1:0]),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sts.hit = hit_q || match;
	assign sts.scan_done = (scan_q >= count_q) && !cmp_vld_q;
	assign sts.full = (count_q == vpdi_pkg::CountW'(vpdi_pkg::TableDepth));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			last_q    <= 1'b0;
			count_q   <= '0;
			scan_q    <= '0;
			cmp_q     <= '0;
			cmp_vld_q <= 1'b0;
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
			out_word  <= '0;
		end else begin
			if (cmd.load) begin
				key_q  <= {in_word.pos_index, in_word.tex_index};
				last_q <= in_word.last_corner;
			end
			if (cmd.scan_start) begin
				scan_q    <= '0;
				cmp_vld_q <= 1'b0;
				hit_q     <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					cmp_vld_q <= (scan_q < count_q);
					cmp_q     <= scan_q;
					if (scan_q < count_q) begin
						scan_q <= scan_q + vpdi_pkg::CountW'(1);
					end
				end else if (match || cmd.clear) begin
					cmp_vld_q <= 1'b0;
				end
				if (match && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cmp_q;
				end
			end
			if (cmd.emit_hit) begin
				out_word.vert_index   <= match && !hit_q ? cmp_q[vpdi_pkg::VertW-1:0]
					: hit_idx_q[vpdi_pkg::VertW-1:0];
				out_word.was_new      <= 1'b0;
				out_word.overflow     <= 1'b0;
				out_word.unique_count <= count_q[vpdi_pkg::UcntW-1:0];
				if (last_q) count_q <= '0;
			end
			if (cmd.emit_miss) begin
				out_word.vert_index <= sts.full ? '0 : count_q[vpdi_pkg::VertW-1:0];
				out_word.was_new    <= !sts.full;
				out_word.overflow   <= sts.full;
				out_word.unique_count <= sts.full ? count_q[vpdi_pkg::UcntW-1:0]
					: new_count[vpdi_pkg::UcntW-1:0];
				if (last_q) count_q <= '0;
				else if (!sts.full) count_q <= new_count;
			end
		end
	end
endmodule

// ----- hdl/vpdi_ctrl.sv -----
// ----------------------------------------------------------------------------
// vpdi_ctrl
// Sequencer: load, scan the table, emit a result word, handshake.
// ----------------------------------------------------------------------------
module vpdi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  vpdi_pkg::ctl_sts_t sts,
	output vpdi_pkg::ctl_cmd_t cmd
);
	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;
	state_t state_q;
	logic   emit_go;

	assign emit_go = (state_q == ST_SCAN) && (sts.hit || sts.scan_done)
		&& (!out_valid || out_ready);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load       = in_valid && in_ready;
		cmd.scan_start = in_valid && in_ready;
		cmd.scan_step  = (state_q == ST_SCAN) && !sts.hit && !sts.scan_done;
		cmd.emit_hit   = emit_go && sts.hit;
		cmd.append     = emit_go && !sts.hit && !sts.full;
		cmd.emit_miss  = emit_go && !sts.hit;
		cmd.clear      = emit_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (emit_go) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SCAN;
				ST_SCAN: if (emit_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- tb/vertex_pair_dedupe_indexer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_pair_dedupe_indexer_core_tb
// Feeds triangle corners and checks each returned table number, append flag,
// overflow flag and unique count against an in-bench model of the pair table.
// ----------------------------------------------------------------------------
module vertex_pair_dedupe_indexer_core_tb;
	localparam int MaxIdle = 20000;

	logic clk;
	logic arst_n;

	vpdi_if #(.word_t(vpdi_pkg::in_word_t))  corner_ch ();
	vpdi_if #(.word_t(vpdi_pkg::out_word_t)) vert_ch ();

	vertex_pair_dedupe_indexer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (corner_ch.sink),
		.out_ch (vert_ch.source)
	);

	logic [vpdi_pkg::KeyW-1:0] pairs [vpdi_pkg::TableDepth];
	int                        pair_cnt = 0;
	vpdi_pkg::in_word_t        corner_q [$];
	vpdi_pkg::out_word_t       vert_q [$];
	int                        mismatches = 0;
	int                        words_in = 0;
	int                        words_out = 0;
	int                        overflows = 0;
	int                        models = 0;
	int                        idle_cycles;
	bit                        hold_out = 0;
	bit                        drain_req = 0;
	int                        tx_gap;
	int                        rx_gap;

	function automatic vpdi_pkg::out_word_t map_corner(vpdi_pkg::in_word_t c);
		vpdi_pkg::out_word_t r;
		logic [vpdi_pkg::KeyW-1:0] key;
		bit hit;
		key = {c.pos_index, c.tex_index};
		hit = 0;
		r = '0;
		for (int v = 0; v < pair_cnt; v++) begin
			if (!hit && pairs[v] == key) begin
				hit = 1;
				r.vert_index = v[vpdi_pkg::VertW-1:0];
			end
		end
		if (!hit) begin
			if (pair_cnt < vpdi_pkg::TableDepth) begin
				pairs[pair_cnt] = key;
				r.vert_index = pair_cnt[vpdi_pkg::VertW-1:0];
				r.was_new = 1;
				pair_cnt++;
			end else begin
				r.overflow = 1;
			end
		end
		r.unique_count = pair_cnt[vpdi_pkg::UcntW-1:0];
		if (c.last_corner)
			pair_cnt = 0;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic vpdi_pkg::in_word_t mk(int p, int t, bit l);
		vpdi_pkg::in_word_t c;
		c.pos_index = p[vpdi_pkg::PosW-1:0];
		c.tex_index = t[vpdi_pkg::TexW-1:0];
		c.last_corner = l;
		return c;
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_ch.valid <= 0;
			corner_ch.data <= '0;
			tx_gap <= 0;
		end else if (corner_ch.valid && !corner_ch.ready) begin
		end else if (tx_gap > 0) begin
			corner_ch.valid <= 0;
			tx_gap <= tx_gap - 1;
		end else if (drain_req && vert_q.size() != 0) begin
			corner_ch.valid <= 0;
		end else if (corner_q.size() != 0 && !(drain_req && corner_ch.valid)) begin
			corner_ch.valid <= 1;
			corner_ch.data <= corner_q.pop_front();
			tx_gap <= pick_gap();
		end else begin
			corner_ch.valid <= 0;
		end
	end

	// monitor, receiver stalls and prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_ch.ready <= 0;
			rx_gap <= 0;
			idle_cycles <= 0;
		end else begin
			if (corner_ch.valid && corner_ch.ready) begin
				vert_q.push_back(map_corner(corner_ch.data));
				words_in++;
				if (corner_ch.data.last_corner)
					models++;
			end
			if (vert_ch.valid && vert_ch.ready) begin
				words_out++;
				if (vert_ch.data.overflow)
					overflows++;
				if (vert_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected word %p", vert_ch.data);
				end else if (vert_q[0] !== vert_ch.data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: word %0d expected %p got %p",
							words_out, vert_q[0], vert_ch.data);
					void'(vert_q.pop_front());
				end else begin
					void'(vert_q.pop_front());
				end
			end
			if ((corner_ch.valid && corner_ch.ready) || (vert_ch.valid && vert_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (hold_out) begin
				vert_ch.ready <= 0;
			end else if (rx_gap > 0) begin
				vert_ch.ready <= 0;
				rx_gap <= rx_gap - 1;
			end else begin
				vert_ch.ready <= 1;
				if ($urandom_range(0, 3) == 0)
					rx_gap <= pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= MaxIdle) begin
			$display("Timeout after %0d idle cycles", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int n;
		int base;
		int npos;
		int ntex;
		int len;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, repeats, last corner
		corner_q.push_back(mk(0, 0, 0));
		corner_q.push_back(mk(2047, 65535, 0));
		corner_q.push_back(mk(0, 0, 0));
		corner_q.push_back(mk(2047, 0, 0));
		corner_q.push_back(mk(0, 65535, 0));
		corner_q.push_back(mk(2047, 65535, 0));
		corner_q.push_back(mk(1365, 43690, 0));
		corner_q.push_back(mk(682, 21845, 1));
		corner_q.push_back(mk(682, 21845, 1));
		corner_q.push_back(mk(0, 0, 0));
		corner_q.push_back(mk(0, 0, 1));

		// long receiver stall while corners keep coming
		wait (corner_q.size() == 0);
		hold_out = 1;
		for (int i = 0; i < 12; i++)
			corner_q.push_back(mk($urandom_range(0, 7), $urandom_range(0, 3), 0));
		repeat (300) @(posedge clk);
		hold_out = 0;

		// models with heavy reuse of small index pools
		n = 0;
		while (n < 1127) begin
			npos = $urandom_range(1, 12);
			ntex = $urandom_range(1, 4);
			base = $urandom_range(0, 2047 - npos);
			len = $urandom_range(3, 40);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0)
					corner_q.push_back(mk($urandom_range(0, 2047),
						$urandom_range(0, 65535), 0));
				else
					corner_q.push_back(mk(base + $urandom_range(0, npos - 1),
						($urandom_range(0, 65535) & ~3) | $urandom_range(0, ntex - 1),
						0));
				n++;
			end
			corner_q.push_back(mk(base, $urandom_range(0, 65535), $urandom_range(0, 9) != 0));
			n++;
			if (n < 45 || $urandom_range(0, 19) == 0) begin
				wait (corner_q.size() == 0);
				drain_req = 1;
				wait (vert_q.size() == 0 && !corner_ch.valid);
				drain_req = 0;
			end
			wait (corner_q.size() < 64);
		end

		wait (corner_q.size() == 0);
		@(posedge clk);
		wait (!corner_ch.valid && vert_q.size() == 0);
		repeat (vpdi_pkg::TableDepth + 20) @(posedge clk);
		$display("Covered %0d corners over %0d models, %0d results, %0d overflow results",
			words_in, models, words_out, overflows);
		if (mismatches == 0 && vert_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d words left", mismatches, vert_q.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ----- vertex_pair_dedupe_indexer_core.f -----
hdl/vpdi_pkg.sv
hdl/vpdi_if.sv
hdl/vpdi_ram.sv
hdl/vpdi_datapath.sv
hdl/vpdi_ctrl.sv
hdl/vertex_pair_dedupe_indexer_core.sv
tb/vertex_pair_dedupe_indexer_core_tb.sv
